[src/i2r_pkg.sv]
// Package: shared types, symbol codes and the greedy rule table for the roman emitter.
`timescale 1ns / 1ps
package i2r_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned SymW    = 7;
  localparam int unsigned RuleW   = 4;
  localparam int unsigned RuleCnt = 13;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [RuleW-1:0] RuleLast = RuleW'(RuleCnt - 1);

  localparam logic [SymW-1:0] SymI = 7'h49;
  localparam logic [SymW-1:0] SymV = 7'h56;
  localparam logic [SymW-1:0] SymX = 7'h58;
  localparam logic [SymW-1:0] SymL = 7'h4C;
  localparam logic [SymW-1:0] SymC = 7'h43;
  localparam logic [SymW-1:0] SymD = 7'h44;
  localparam logic [SymW-1:0] SymM = 7'h4D;

  // One value waiting between front and back.
  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
  } i2r_job_t;

  function automatic logic [ValueW-1:0] rule_amount(input logic [RuleW-1:0] idx);
    logic [ValueW-1:0] a;
    case (idx)
      4'd0:    a = 12'd1000;
      4'd1:    a = 12'd900;
      4'd2:    a = 12'd500;
      4'd3:    a = 12'd400;
      4'd4:    a = 12'd100;
      4'd5:    a = 12'd90;
      4'd6:    a = 12'd50;
      4'd7:    a = 12'd40;
      4'd8:    a = 12'd10;
      4'd9:    a = 12'd9;
      4'd10:   a = 12'd5;
      4'd11:   a = 12'd4;
      default: a = 12'd1;
    endcase
    return a;
  endfunction

  function automatic logic [SymW-1:0] rule_first(input logic [RuleW-1:0] idx);
    logic [SymW-1:0] s;
    case (idx)
      4'd0:    s = SymM;
      4'd1:    s = SymC;
      4'd2:    s = SymD;
      4'd3:    s = SymC;
      4'd4:    s = SymC;
      4'd5:    s = SymX;
      4'd6:    s = SymL;
      4'd7:    s = SymX;
      4'd8:    s = SymX;
      4'd9:    s = SymI;
      4'd10:   s = SymV;
      4'd11:   s = SymI;
      default: s = SymI;
    endcase
    return s;
  endfunction

  function automatic logic [SymW-1:0] rule_second(input logic [RuleW-1:0] idx);
    logic [SymW-1:0] s;
    case (idx)
      4'd1:    s = SymM;
      4'd3:    s = SymD;
      4'd5:    s = SymC;
      4'd7:    s = SymL;
      4'd9:    s = SymX;
      4'd11:   s = SymV;
      default: s = SymI;
    endcase
    return s;
  endfunction

  // Subtractive pairs: CM, CD, XC, XL, IX, IV.
  function automatic logic rule_is_pair(input logic [RuleW-1:0] idx);
    return idx inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11};
  endfunction

  function automatic logic rule_repeats(input logic [RuleW-1:0] idx);
    return idx inside {4'd0, 4'd4, 4'd8, 4'd12};
  endfunction

endpackage

[src/i2r_front.sv]
// Front end: accept input words, drop zero values, hand jobs to the queue.
`timescale 1ns / 1ps
module i2r_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [i2r_pkg::ValueW-1:0]   in_value_i,
  output i2r_pkg::i2r_job_t            job_o,
  input  logic                         job_ready_i
);

  logic                       hold_q, hold_d;
  logic [i2r_pkg::ValueW-1:0] value_q, value_d;
  logic                       in_fire;

  assign in_ready_o = !hold_q || job_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    hold_d  = hold_q;
    value_d = value_q;
    if (hold_q && job_ready_i) begin
      hold_d = 1'b0;
    end
    // zero has no numeral: accept it and drop it
    if (in_fire) begin
      hold_d  = (in_value_i != '0);
      value_d = in_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign job_o.valid = hold_q;
  assign job_o.value = value_q;

endmodule

[src/i2r_queue.sv]
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
module i2r_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  i2r_pkg::i2r_job_t push_i,
  output logic              push_ready_o,
  output i2r_pkg::i2r_job_t pop_o,
  input  logic              pop_ready_i
);

  logic [i2r_pkg::ValueW-1:0] mem_q [i2r_pkg::QDepth];
  logic [i2r_pkg::QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [i2r_pkg::QCntW-1:0]  cnt_q, cnt_d;
  logic                       push, pop;

  assign push_ready_o = (cnt_q != i2r_pkg::QCntW'(i2r_pkg::QDepth));
  assign push         = push_i.valid && push_ready_o;
  assign pop          = (cnt_q != '0) && pop_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_i.value;
    end
  end

  assign pop_o.valid = (cnt_q != '0);
  assign pop_o.value = mem_q[rd_q];

  cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= i2r_pkg::QCntW'(i2r_pkg::QDepth))
    else $error("queue count beyond depth");

endmodule

[src/i2r_back.sv]
// Back end: greedy roman sequencer, one character per cycle into the output register while that register is free.
`timescale 1ns / 1ps
module i2r_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  i2r_pkg::i2r_job_t          job_i,
  output logic                       job_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [i2r_pkg::SymW-1:0]   out_symbol_o,
  output logic                       out_last_o
);

  logic                       busy_q, busy_d;
  logic                       second_q, second_d;
  logic [i2r_pkg::ValueW-1:0] rem_q, rem_d;
  logic [i2r_pkg::RuleW-1:0]  rule_q, rule_d;
  logic                       ovalid_q, ovalid_d;
  logic [i2r_pkg::SymW-1:0]   osym_q, osym_d;
  logic                       olast_q, olast_d;
  logic                       out_free, emit, load;
  logic [i2r_pkg::RuleW-1:0]  sel;
  logic [i2r_pkg::ValueW-1:0] rem_sub;

  assign out_free    = !ovalid_q || out_ready_i;
  assign emit        = busy_q && out_free;
  assign job_ready_o = !busy_q;
  assign load        = job_i.valid && !busy_q;

  // first rule at or after the current one whose amount fits the remainder
  always_comb begin
    sel = i2r_pkg::RuleLast;
    for (int i = i2r_pkg::RuleCnt - 1; i >= 0; i--) begin
      if (i2r_pkg::RuleW'(i) >= rule_q && rem_q >= i2r_pkg::rule_amount(i2r_pkg::RuleW'(i))) begin
        sel = i2r_pkg::RuleW'(i);
      end
    end
  end

  assign rem_sub = rem_q - i2r_pkg::rule_amount(sel);

  always_comb begin
    busy_d   = busy_q;
    second_d = second_q;
    rem_d    = rem_q;
    rule_d   = rule_q;
    ovalid_d = ovalid_q && !out_ready_i;
    osym_d   = osym_q;
    olast_d  = olast_q;
    if (load) begin
      busy_d   = 1'b1;
      second_d = 1'b0;
      rem_d    = job_i.value;
      rule_d   = '0;
    end else if (emit) begin
      ovalid_d = 1'b1;
      if (second_q) begin
        // finish the pair, then move past it
        osym_d   = i2r_pkg::rule_second(rule_q);
        olast_d  = (rem_q == '0);
        second_d = 1'b0;
        rule_d   = rule_q + 1'b1;
        busy_d   = (rem_q != '0);
      end else begin
        osym_d = i2r_pkg::rule_first(sel);
        rem_d  = rem_sub;
        if (i2r_pkg::rule_is_pair(sel)) begin
          second_d = 1'b1;
          rule_d   = sel;
          olast_d  = 1'b0;
        end else begin
          rule_d  = i2r_pkg::rule_repeats(sel) ? sel : sel + 1'b1;
          olast_d = (rem_sub == '0);
          busy_d  = (rem_sub != '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      second_q <= 1'b0;
      rem_q    <= '0;
      rule_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      second_q <= second_d;
      rem_q    <= rem_d;
      rule_q   <= rule_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    osym_q  <= osym_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = ovalid_q;
  assign out_symbol_o = osym_q;
  assign out_last_o   = olast_q;

  second_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> busy_q)
    else $error("pair half owed while idle");

  rem_live_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !second_q |-> rem_q != '0)
    else $error("sequencer busy with nothing left");

  rule_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rule_q <= i2r_pkg::RuleLast)
    else $error("rule index out of table");

  last_ends_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !load && olast_d |=> !busy_q && out_valid_o && out_last_o)
    else $error("final character did not end the numeral");

endmodule

[src/integer_to_roman_emitter_unit.sv]
// Top level: integer to roman numeral emitter, front end, job queue and back end.
//
//  channel   dir  handshake                   tdata / tuser / tlast
//  s_axis    in   s_axis_tvalid/s_axis_tready tdata[11:0] value, [15:12] unused
//  m_axis    out  m_axis_tvalid/m_axis_tready tdata[6:0] symbol, [7] zero; tlast = last
//
// The back-end sequencer first loads a value from the queue, then emits its numeral one
// character per cycle while the output register is free (at most 15 characters).
// The front end registers one word and the queue holds two more, so input keeps flowing
// while the back end works; a zero value is accepted and yields no word.
// Reset clears all control state; no clearing pass is needed.
// A stalled m_axis holds the sequencer in place; the emitted word waits in the output register.
`timescale 1ns / 1ps
module integer_to_roman_emitter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] value, [15:12] unused
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] symbol, [7] zero
  output logic        m_axis_tlast
);

  i2r_pkg::i2r_job_t             front_job, queue_job;
  logic                          push_ready, pop_ready;
  logic [i2r_pkg::SymW-1:0]      symbol;

  i2r_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata[i2r_pkg::ValueW-1:0]),
    .job_o       (front_job),
    .job_ready_i (push_ready)
  );

  i2r_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (front_job),
    .push_ready_o (push_ready),
    .pop_o        (queue_job),
    .pop_ready_i  (pop_ready)
  );

  i2r_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (queue_job),
    .job_ready_o  (pop_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_symbol_o (symbol),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, symbol};

endmodule

[bench/tb.sv]
// Testbench for the integer to roman emitter: directed table, then random values.
`timescale 1ns / 1ps
module tb;

  localparam string Predicted = "*";
  localparam int    TblRows   = 24;
  localparam int    NumRandom = 350;
  localparam int    QuietFrom = 150;
  localparam int    QuietTo   = 220;
  localparam int    MaxShown  = 10;

  typedef struct packed {
    logic [i2r_pkg::SymW-1:0] symbol;
    logic                     last;
  } roman_char_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [11:0] value, [15:12] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [6:0] symbol, [7] zero
  logic        m_axis_tlast;

  roman_char_t pending_chars[$];
  int unsigned misses = 0;
  bit          quiet  = 1'b0;

  // Greedy steps, largest first; only the single-letter powers of ten may repeat.
  int unsigned step_amt [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
  string       step_txt [13] = '{"M", "CM", "D", "CD", "C", "XC", "L", "XL", "X", "IX",
                                 "V", "IV", "I"};
  bit          step_rep [13] = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};

  // Directed rows: a typed numeral where it is obvious, otherwise left to the predictor.
  logic [i2r_pkg::ValueW-1:0] tbl_value [TblRows] = '{
    12'd1, 12'd0, 12'd4095, 12'd3999, 12'd3888, 12'd4, 12'd9, 12'd40,
    12'd90, 12'd400, 12'd900, 12'd5, 12'd50, 12'd500, 12'd1000, 12'd3000,
    12'd0, 12'd4000, 12'd2048, 12'd1994, 12'd2730, 12'd1365, 12'd444, 12'd3};
  string tbl_text [TblRows] = '{
    "I", "", "MMMMXCV", "MMMCMXCIX", "MMMDCCCLXXXVIII", "IV", "IX", "XL",
    "XC", "CD", "CM", "V", "L", "D", "M", "MMM",
    "", "MMMM", Predicted, Predicted, Predicted, Predicted, Predicted, "III"};

  integer_to_roman_emitter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic string spell_roman(input logic [i2r_pkg::ValueW-1:0] v);
    int unsigned rest;
    int unsigned uses;
    string       txt;
    rest = 32'(v);
    txt  = "";
    for (int r = 0; r < 13; r++) begin
      uses = 0;
      while (rest >= step_amt[r] && (step_rep[r] || uses == 0)) begin
        rest -= step_amt[r];
        txt = {txt, step_txt[r]};
        uses++;
      end
    end
    return txt;
  endfunction

  // Queue one word per character; flag the final one.
  function automatic void queue_numeral(input string txt);
    roman_char_t c;
    byte         ch;
    for (int i = 0; i < txt.len(); i++) begin
      ch       = txt.getc(i);
      c.symbol = ch[i2r_pkg::SymW-1:0];
      c.last   = (i == txt.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  task automatic report_miss(input string what, input logic [8:0] want, input logic [8:0] got);
    misses++;
    if (misses <= MaxShown)
      $display("%0t %s: expected '%c' last=%0b, got '%c' (0x%02h) last=%0b", $realtime, what,
               want[7:0], want[8], got[7:0], got[7:0], got[8]);
  endtask

  task automatic send_value(input logic [i2r_pkg::ValueW-1:0] v, input string typed);
    while (!quiet && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(16 - i2r_pkg::ValueW){1'b0}}, v};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    queue_numeral(typed == Predicted ? spell_roman(v) : typed);
  endtask

  always @(posedge clk_i) begin : sink
    roman_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        report_miss("unexpected word", '0, {m_axis_tlast, m_axis_tdata});
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata !== {1'b0, want.symbol} || m_axis_tlast !== want.last)
          report_miss("word mismatch", {want.last, 1'b0, want.symbol},
                      {m_axis_tlast, m_axis_tdata});
      end
    end
    m_axis_tready <= quiet || ($urandom_range(99) >= 29);
  end

  initial begin
    int unsigned                pick;
    logic [i2r_pkg::ValueW-1:0] v;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (tbl_value[i]) send_value(tbl_value[i], tbl_text[i]);
    for (int n = 0; n < NumRandom; n++) begin
      quiet <= (n >= QuietFrom && n < QuietTo);
      pick = $urandom_range(99);
      if (pick < 5)
        v = '0;
      else if (pick < 11)
        v = i2r_pkg::ValueW'($urandom_range(4095, 4000));
      else
        v = i2r_pkg::ValueW'($urandom_range(3999, 1));
      send_value(v, Predicted);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    // Catch any stray word after the last numeral.
    repeat (40) @(posedge clk_i);
    if (misses == 0) begin
      $display("** integer_to_roman_emitter_unit: PASSED **");
    end else begin
      $display("** integer_to_roman_emitter_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** integer_to_roman_emitter_unit: FAILED **");
    $finish;
  end

endmodule
